[rtl/modexp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg: shared definitions of the modular exponentiation unit
// Operand width, register map and the request and status records passed
// between the sequencer and the bit-serial modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // operand width of base, exponent, modulus and power
    localparam int WIDTH  = 32;
    // configuration bus data width
    localparam int DATA_W = (WIDTH > 32) ? 64 : 32;
    // configuration address width: two registers, word or double-word spaced
    localparam int ADDR_W = (WIDTH > 32) ? 4 : 3;
    // bit that selects the register inside the address
    localparam int SEL_BIT = ADDR_W - 1;
    // bit counter of the multiplier
    localparam int CNT_W  = $clog2(WIDTH);

    // register selector codes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // request to the modular multiplier
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] m;
    } mul_req_t;

    // status of the modular multiplier
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] result;
    } mul_stat_t;

endpackage

[rtl/modular_exponentiation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base ^ exponent mod modulus
// Right-to-left square-and-multiply over a shared bit-serial modular
// multiplier, with exponent and modulus held in configuration registers.
// ----------------------------------------------------------------------------
// Usage
// - exponent (address 0) and modulus (address 4) are written over the APB
//   port while the unit is idle; reset loads exponent 1 and modulus 2
// - a transaction is accepted on a rising edge with start high and busy low;
//   base is sampled on that edge
// - the result appears on power for exactly one cycle with done high; the
//   receiver cannot stall it, and a new start may be given in that cycle
// Sequence
// - every modular product runs through the multiplier, one bit of the
//   multiplier operand per cycle
// - the base is first reduced by one such pass, then one squaring per
//   exponent bit up to its highest set bit plus one product per set bit,
//   and one decision step per exponent bit
// - no multiplier pass runs when the modulus is below 2 (power is 0)
// - one transaction at a time; busy stays high until the result is issued
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [modexp_pkg::WIDTH-1:0]    base,
    // result channel
    output logic                            done,
    output logic [modexp_pkg::WIDTH-1:0]    power,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [modexp_pkg::ADDR_W-1:0]   paddr,
    input  logic [modexp_pkg::DATA_W-1:0]   pwdata,
    output logic [modexp_pkg::DATA_W-1:0]   prdata,
    output logic                            pready
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_SQR
    } state_t;

    state_t                       state_reg, state_next;
    logic [modexp_pkg::WIDTH-1:0] exponent_reg, exponent_next;
    logic [modexp_pkg::WIDTH-1:0] modulus_reg, modulus_next;
    logic [modexp_pkg::WIDTH-1:0] e_reg, e_next;
    logic [modexp_pkg::WIDTH-1:0] acc_reg, acc_next;
    logic [modexp_pkg::WIDTH-1:0] sq_reg, sq_next;
    logic [modexp_pkg::WIDTH-1:0] op_a_reg, op_a_next;
    logic [modexp_pkg::WIDTH-1:0] op_b_reg, op_b_next;
    logic [modexp_pkg::WIDTH-1:0] power_reg, power_next;
    logic                         start_reg, start_next;
    logic                         done_reg, done_next;

    modexp_pkg::mul_req_t         mul_req;
    modexp_pkg::mul_stat_t        mul_stat;

    // shared modular multiplier
    assign mul_req.start = start_reg;
    assign mul_req.a     = op_a_reg;
    assign mul_req.b     = op_b_reg;
    assign mul_req.m     = modulus_reg;

    modexp_mulmod u_mulmod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .stat  (mul_stat)
    );

    // sequencer and register writes
    always_comb
    begin
        state_next    = state_reg;
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        e_next        = e_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        power_next    = power_reg;
        start_next    = 1'b0;
        done_next     = 1'b0;

        // configuration write
        if (psel && penable && pwrite)
        begin
            case (paddr[modexp_pkg::SEL_BIT])
                modexp_pkg::REG_EXPONENT: exponent_next = pwdata[modexp_pkg::WIDTH-1:0];
                modexp_pkg::REG_MODULUS:  modulus_next  = pwdata[modexp_pkg::WIDTH-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    e_next   = exponent_reg;
                    acc_next = modexp_pkg::WIDTH'(1);
                    if (modulus_reg < modexp_pkg::WIDTH'(2))
                    begin
                        // degenerate modulus gives zero
                        power_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        // reduce base as 1 * base mod m
                        op_a_next  = modexp_pkg::WIDTH'(1);
                        op_b_next  = base;
                        start_next = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_stat.done)
                begin
                    sq_next    = mul_stat.result;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    power_next = acc_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (e_reg[0])
                begin
                    op_a_next  = acc_reg;
                    op_b_next  = sq_reg;
                    start_next = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    op_a_next  = sq_reg;
                    op_b_next  = sq_reg;
                    start_next = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next   = mul_stat.result;
                    op_a_next  = sq_reg;
                    op_b_next  = sq_reg;
                    start_next = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mul_stat.done)
                begin
                    sq_next    = mul_stat.result;
                    e_next     = {1'b0, e_reg[modexp_pkg::WIDTH-1:1]};
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            exponent_reg <= modexp_pkg::WIDTH'(1);
            modulus_reg  <= modexp_pkg::WIDTH'(2);
            start_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
            start_reg    <= start_next;
            done_reg     <= done_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        op_a_reg  <= op_a_next;
        op_b_reg  <= op_b_next;
        power_reg <= power_next;
    end

    // configuration read back
    always_comb
    begin
        case (paddr[modexp_pkg::SEL_BIT])
            modexp_pkg::REG_EXPONENT: prdata = modexp_pkg::DATA_W'(exponent_reg);
            modexp_pkg::REG_MODULUS:  prdata = modexp_pkg::DATA_W'(modulus_reg);
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign power  = power_reg;

    // checks
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither started nor completed");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still running");

    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == ST_REDUCE || state_reg == ST_MUL
                           || state_reg == ST_SQR))
        else $error("multiplier result arrived with no product pending");

endmodule

[rtl/modexp_mulmod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_mulmod: bit-serial modular multiplier
// Computes a * b mod m by scanning b from its top bit, one bit per cycle:
// the partial result is doubled modulo m, then a is added modulo m when the
// bit is set. done pulses with the result.
// ----------------------------------------------------------------------------
module modexp_mulmod
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  modexp_pkg::mul_req_t  req,
    output modexp_pkg::mul_stat_t stat
);

    logic [modexp_pkg::WIDTH-1:0] a_reg, a_next;
    logic [modexp_pkg::WIDTH-1:0] b_reg, b_next;
    logic [modexp_pkg::WIDTH-1:0] m_reg, m_next;
    logic [modexp_pkg::WIDTH-1:0] r_reg, r_next;
    logic [modexp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [modexp_pkg::WIDTH:0]   dbl;
    logic [modexp_pkg::WIDTH-1:0] dbl_red;
    logic [modexp_pkg::WIDTH:0]   sum;
    logic [modexp_pkg::WIDTH-1:0] sum_red;

    // one step: double modulo m, then conditionally add a modulo m
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? modexp_pkg::WIDTH'(dbl - {1'b0, m_reg})
                                          : modexp_pkg::WIDTH'(dbl);
        sum     = {1'b0, dbl_red} + ((b_reg[modexp_pkg::WIDTH-1])
                                     ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, m_reg}) ? modexp_pkg::WIDTH'(sum - {1'b0, m_reg})
                                          : modexp_pkg::WIDTH'(sum);
    end

    // next state
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
            r_next    = '0;
            cnt_next  = modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red;
            b_next   = {b_reg[modexp_pkg::WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign stat.done   = done_reg;
    assign stat.result = r_reg;

    // checks
    a_last_bit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == '0 && !req.start) |=> done_reg)
        else $error("multiplier did not finish after its last bit");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("multiplier did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !$past(req.start)) |-> !busy_reg)
        else $error("multiplier busy while reporting done");

endmodule
